>>> rtl/wlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlf_pkg
// Shared types and constants for the weighted link flow step block.
// ----------------------------------------------------------------------------
package wlf_pkg;

   localparam int OCC_W   = 32;   // Q16.16 occupancy
   localparam int WGT_W   = 17;   // Q1.16 weight, 65536 is one
   localparam int NODE_FW = 10;   // node field of a request
   localparam int GAIN_W  = 16;   // Q4.12 gain
   localparam int STEP_W  = 16;
   localparam int STS_W   = 2;
   localparam int REQ_W   = 3;
   localparam int DVD_W   = 34;   // normalize dividend width
   localparam int P_W     = 36;   // occupancy times gain, Q20.16
   localparam int ADD_W   = 38;   // contribution of one link

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4506;
   localparam logic [WGT_W-1:0]  ONE_Q16    = 17'h10000;

   localparam logic [REQ_W-1:0] REQ_ADD  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_SET  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_NORM = 3'd2;
   localparam logic [REQ_W-1:0] REQ_RUN  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_READ = 3'd4;

   localparam logic [STS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STS_W-1:0] ST_SAT  = 2'd2;

   localparam int ACT_W = 5;
   localparam logic [ACT_W-1:0] A_NOP       = 5'd0;
   localparam logic [ACT_W-1:0] A_LATCH     = 5'd1;
   localparam logic [ACT_W-1:0] A_CLEAR     = 5'd2;
   localparam logic [ACT_W-1:0] A_RD_REQ    = 5'd3;
   localparam logic [ACT_W-1:0] A_RD_NODE   = 5'd4;
   localparam logic [ACT_W-1:0] A_ADD_WR    = 5'd5;
   localparam logic [ACT_W-1:0] A_SET_OCC   = 5'd6;
   localparam logic [ACT_W-1:0] A_RES_OCC   = 5'd7;
   localparam logic [ACT_W-1:0] A_TOT_CLR   = 5'd8;
   localparam logic [ACT_W-1:0] A_RD_LINK   = 5'd9;
   localparam logic [ACT_W-1:0] A_TOT_ADD   = 5'd10;
   localparam logic [ACT_W-1:0] A_DIV_START = 5'd11;
   localparam logic [ACT_W-1:0] A_LINK_WB   = 5'd12;
   localparam logic [ACT_W-1:0] A_NEXT_CLR  = 5'd13;
   localparam logic [ACT_W-1:0] A_MUL_P     = 5'd14;
   localparam logic [ACT_W-1:0] A_MUL_W     = 5'd15;
   localparam logic [ACT_W-1:0] A_ADD_COMB  = 5'd16;
   localparam logic [ACT_W-1:0] A_ACC_WR    = 5'd17;
   localparam logic [ACT_W-1:0] A_RD_NEXT_N = 5'd18;
   localparam logic [ACT_W-1:0] A_COPY      = 5'd19;

   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic             rsp_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic node_ok;
      logic dest_ok;
      logic p_zero;
      logic tot_zero;
      logic div_done;
      logic sat;
   } sts_type;

endpackage

>>> rtl/wlf_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlf_chan_if
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wlf_req_if;
   logic                        valid;
   logic                        ready;
   logic [wlf_pkg::REQ_W-1:0]   req_type;
   logic [wlf_pkg::NODE_FW-1:0] node;
   logic [wlf_pkg::NODE_FW-1:0] dest_node;
   logic [wlf_pkg::WGT_W-1:0]   raw_weight;
   logic [wlf_pkg::OCC_W-1:0]   occupancy_in;
   logic [wlf_pkg::STEP_W-1:0]  step_count;

   modport source (output valid, req_type, node, dest_node, raw_weight, occupancy_in,
                   step_count, input ready);
   modport sink   (input valid, req_type, node, dest_node, raw_weight, occupancy_in,
                   step_count, output ready);
endinterface

interface wlf_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [wlf_pkg::OCC_W-1:0] occupancy_out;
   logic [wlf_pkg::STS_W-1:0] status;

   modport source (output valid, occupancy_out, status, input ready);
   modport sink   (input valid, occupancy_out, status, output ready);
endinterface

>>> rtl/wlf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wlf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

>>> rtl/wlf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlf_div
// Restoring divider, one quotient bit per cycle, for weight normalization.
// ----------------------------------------------------------------------------
module wlf_div #(
   parameter int TW = 22
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [wlf_pkg::DVD_W-1:0] dividend,
   input  logic [TW-1:0]             divisor,
   output logic                      done,
   output logic [wlf_pkg::WGT_W-1:0] quotient
);
   import wlf_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] a_ff, a_in;
   logic [TW-1:0]    rem_ff, rem_in;
   logic [TW:0]      shifted;
   logic             q_bit;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      rem_in  = rem_ff;
      shifted = {rem_ff, a_ff[DVD_W-1]};
      q_bit   = (shifted >= {1'b0, divisor});
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CNT_W'(DVD_W);
         a_in    = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = q_bit ? TW'(shifted - {1'b0, divisor}) : shifted[TW-1:0];
         a_in   = {a_ff[DVD_W-2:0], q_bit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = a_ff[WGT_W-1:0];
endmodule

>>> rtl/wlf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlf_datapath
// Graph memories, gain register, multipliers and accumulators.
// ----------------------------------------------------------------------------
module wlf_datapath #(
   parameter int NODES     = 1024,
   parameter int MAX_LINKS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_wr_en,
   input  logic [wlf_pkg::GAIN_W-1:0]             csr_wr_data,
   input  logic [wlf_pkg::NODE_FW-1:0]            node,
   input  logic [wlf_pkg::NODE_FW-1:0]            dest_node,
   input  logic [wlf_pkg::WGT_W-1:0]              raw_weight,
   input  logic [wlf_pkg::OCC_W-1:0]              occupancy_in,
   input  wlf_pkg::cmd_type                       cmd,
   input  logic [$clog2(NODES)-1:0]               cmd_node,
   input  logic [((MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1)-1:0] cmd_link,
   output wlf_pkg::sts_type                       sts,
   output logic [$clog2(MAX_LINKS + 1)-1:0]       cnt_rd,
   output logic [wlf_pkg::OCC_W-1:0]              rsp_occ
);
   import wlf_pkg::*;

   localparam int NW  = $clog2(NODES);
   localparam int LW  = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
   localparam int CW  = $clog2(MAX_LINKS + 1);
   localparam int TW  = WGT_W + LW;
   localparam int LAW = NW + LW;
   localparam int LKW = NODE_FW + WGT_W;
   localparam int HP  = P_W / 2;

   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [NODE_FW-1:0] node_ff, dest_ff, tgt_ff;
   logic [WGT_W-1:0]   raw_ff;
   logic [OCC_W-1:0]   occin_ff, result_ff, result_in, rsp_occ_ff;
   logic [TW-1:0]      total_ff, total_in;
   logic [P_W-1:0]     p_ff;
   logic [HP+WGT_W-1:0] plo_ff, phi_ff;
   logic [ADD_W-1:0]   add_ff;
   logic               sat_ff, sat_in;

   logic [NW-1:0]      node_idx, dest_idx;
   logic [OCC_W-1:0]   occ_rd, next_rd;
   logic [LKW-1:0]     link_rd;
   logic [WGT_W-1:0]   w_rd, w_clip, quotient;
   logic [NODE_FW-1:0] t_rd;
   logic [47:0]        p_full;
   logic [53:0]        comb_sum;
   logic [ADD_W:0]     acc_sum;
   logic               tgt_ok;

   // memory ports
   logic              cnt_we, occ_we, lnk_we, nxt_we, node_re, lnk_re, nxt_re;
   logic [NW-1:0]     cnt_wa, occ_wa, node_ra, nxt_wa, nxt_ra;
   logic [CW-1:0]     cnt_wd;
   logic [OCC_W-1:0]  occ_wd, nxt_wd;
   logic [LAW-1:0]    lnk_wa, lnk_ra;
   logic [LKW-1:0]    lnk_wd;
   logic              div_done;
   logic [DVD_W-1:0]  dividend;

   assign node_idx = NW'(node_ff);
   assign dest_idx = NW'(tgt_ff);
   assign w_rd     = link_rd[WGT_W-1:0];
   assign t_rd     = link_rd[LKW-1:WGT_W];
   assign w_clip   = (raw_ff > ONE_Q16) ? ONE_Q16 : raw_ff;
   assign tgt_ok   = (32'(tgt_ff) < 32'(NODES));
   assign p_full   = 48'(occ_rd) * 48'(gain_ff);
   assign comb_sum = 54'({phi_ff, HP'(0)}) + 54'(plo_ff);
   assign acc_sum  = (ADD_W + 1)'(next_rd) + (ADD_W + 1)'(add_ff);
   assign dividend = DVD_W'({w_rd, 16'b0}) + DVD_W'(total_ff >> 1);

   always_comb begin
      node_re = (cmd.act == A_RD_REQ) || (cmd.act == A_RD_NODE);
      node_ra = (cmd.act == A_RD_REQ) ? node_idx : cmd_node;

      cnt_we = (cmd.act == A_CLEAR) || (cmd.act == A_ADD_WR);
      cnt_wa = (cmd.act == A_ADD_WR) ? node_idx : cmd_node;
      cnt_wd = (cmd.act == A_ADD_WR) ? CW'(cnt_rd + 1'b1) : '0;

      occ_we = (cmd.act == A_CLEAR) || (cmd.act == A_SET_OCC) || (cmd.act == A_COPY);
      occ_wa = (cmd.act == A_SET_OCC) ? node_idx : cmd_node;
      occ_wd = (cmd.act == A_SET_OCC) ? occin_ff :
               (cmd.act == A_COPY)    ? next_rd  : '0;

      lnk_re = (cmd.act == A_RD_LINK);
      lnk_ra = {cmd_node, cmd_link};
      lnk_we = (cmd.act == A_ADD_WR) || (cmd.act == A_LINK_WB);
      lnk_wa = (cmd.act == A_ADD_WR) ? {node_idx, cnt_rd[LW-1:0]} : {cmd_node, cmd_link};
      lnk_wd = (cmd.act == A_ADD_WR) ? {dest_ff, w_clip} : {t_rd, quotient};

      nxt_re = (cmd.act == A_ADD_COMB) || (cmd.act == A_RD_NEXT_N);
      nxt_ra = (cmd.act == A_ADD_COMB) ? dest_idx : cmd_node;
      nxt_we = (cmd.act == A_NEXT_CLR) || ((cmd.act == A_ACC_WR) && tgt_ok);
      nxt_wa = (cmd.act == A_NEXT_CLR) ? cmd_node : dest_idx;
      nxt_wd = (cmd.act == A_NEXT_CLR) ? '0 :
               (acc_sum[ADD_W:OCC_W] != '0) ? '1 : acc_sum[OCC_W-1:0];
   end

   always_comb begin
      gain_in   = csr_wr_en ? csr_wr_data : gain_ff;
      result_in = result_ff;
      total_in  = total_ff;
      sat_in    = sat_ff;
      if (cmd.act == A_LATCH) begin
         result_in = '0;
         sat_in    = 1'b0;
      end
      if (cmd.act == A_RES_OCC) begin
         result_in = occ_rd;
      end
      if (cmd.act == A_TOT_CLR) begin
         total_in = '0;
      end
      if (cmd.act == A_TOT_ADD) begin
         total_in = TW'(total_ff + TW'(w_rd));
      end
      if (cmd.act == A_ACC_WR && tgt_ok && acc_sum[ADD_W:OCC_W] != '0) begin
         sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
      result_ff <= result_in;
      total_ff  <= total_in;
      sat_ff    <= sat_in;
      if (cmd.act == A_LATCH) begin
         node_ff  <= node;
         dest_ff  <= dest_node;
         raw_ff   <= raw_weight;
         occin_ff <= occupancy_in;
      end
      if (cmd.act == A_MUL_P) begin
         p_ff <= p_full[47:12];
      end
      if (cmd.act == A_MUL_W) begin
         plo_ff <= p_ff[HP-1:0] * w_rd;
         phi_ff <= p_ff[P_W-1:HP] * w_rd;
         tgt_ff <= t_rd;
      end
      if (cmd.act == A_ADD_COMB) begin
         add_ff <= comb_sum[53:16];
      end
      if (cmd.rsp_load) begin
         rsp_occ_ff <= result_ff;
      end
   end

   wlf_ram #(.WIDTH(CW), .DEPTH(NODES)) u_cnt_ram (
      .clock, .wr_en(cnt_we), .wr_addr(cnt_wa), .wr_data(cnt_wd),
      .rd_en(node_re), .rd_addr(node_ra), .rd_data(cnt_rd));

   wlf_ram #(.WIDTH(OCC_W), .DEPTH(NODES)) u_occ_ram (
      .clock, .wr_en(occ_we), .wr_addr(occ_wa), .wr_data(occ_wd),
      .rd_en(node_re), .rd_addr(node_ra), .rd_data(occ_rd));

   wlf_ram #(.WIDTH(OCC_W), .DEPTH(NODES)) u_next_ram (
      .clock, .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_en(nxt_re), .rd_addr(nxt_ra), .rd_data(next_rd));

   wlf_ram #(.WIDTH(LKW), .DEPTH(NODES << LW)) u_link_ram (
      .clock, .wr_en(lnk_we), .wr_addr(lnk_wa), .wr_data(lnk_wd),
      .rd_en(lnk_re), .rd_addr(lnk_ra), .rd_data(link_rd));

   wlf_div #(.TW(TW)) u_div (
      .clock, .reset, .start(cmd.act == A_DIV_START), .dividend,
      .divisor(total_ff), .done(div_done), .quotient);

   assign sts.full     = (cnt_rd >= CW'(MAX_LINKS));
   assign sts.node_ok  = (32'(node_ff) < 32'(NODES));
   assign sts.dest_ok  = (32'(dest_ff) < 32'(NODES));
   assign sts.p_zero   = (p_ff == '0);
   assign sts.tot_zero = (total_ff == '0);
   assign sts.div_done = div_done;
   assign sts.sat      = sat_ff;
   assign rsp_occ      = rsp_occ_ff;
endmodule

>>> rtl/wlf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlf_ctrl
// Request sequencer: clear pass, link append, normalize and step loops.
// ----------------------------------------------------------------------------
module wlf_ctrl #(
   parameter int NODES     = 1024,
   parameter int MAX_LINKS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [wlf_pkg::REQ_W-1:0]              req_type,
   input  logic [wlf_pkg::STEP_W-1:0]             step_count,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [wlf_pkg::STS_W-1:0]              rsp_status,
   output wlf_pkg::cmd_type                       cmd,
   output logic [$clog2(NODES)-1:0]               cmd_node,
   output logic [((MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1)-1:0] cmd_link,
   input  wlf_pkg::sts_type                       sts,
   input  logic [$clog2(MAX_LINKS + 1)-1:0]       cnt_rd
);
   import wlf_pkg::*;

   localparam int NW = $clog2(NODES);
   localparam int LW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
   localparam int CW = $clog2(MAX_LINKS + 1);

   localparam logic [4:0] S_CLEAR    = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_ADD_RD   = 5'd2;
   localparam logic [4:0] S_ADD_WR   = 5'd3;
   localparam logic [4:0] S_SET      = 5'd4;
   localparam logic [4:0] S_READ_RD  = 5'd5;
   localparam logic [4:0] S_READ_RES = 5'd6;
   localparam logic [4:0] S_DONE     = 5'd7;
   localparam logic [4:0] N_NODE     = 5'd8;
   localparam logic [4:0] N_TOT0     = 5'd9;
   localparam logic [4:0] N_SUM_RD   = 5'd10;
   localparam logic [4:0] N_SUM_ADD  = 5'd11;
   localparam logic [4:0] N_CHK      = 5'd12;
   localparam logic [4:0] N_DIV_RD   = 5'd13;
   localparam logic [4:0] N_DIV_GO   = 5'd14;
   localparam logic [4:0] N_DIV_WAIT = 5'd15;
   localparam logic [4:0] P_START    = 5'd16;
   localparam logic [4:0] P_CLR      = 5'd17;
   localparam logic [4:0] P_NODE     = 5'd18;
   localparam logic [4:0] P_MULP     = 5'd19;
   localparam logic [4:0] P_LINK     = 5'd20;
   localparam logic [4:0] P_MULW     = 5'd21;
   localparam logic [4:0] P_COMB     = 5'd22;
   localparam logic [4:0] P_ACC      = 5'd23;
   localparam logic [4:0] P_CPY_RD   = 5'd24;
   localparam logic [4:0] P_CPY_WR   = 5'd25;

   logic [4:0]        state_ff, state_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [CW-1:0]     k_ff, k_in, cnt_ff, cnt_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [REQ_W-1:0]  rtype_ff, rtype_in;
   logic [STS_W-1:0]  status_ff, status_in, rsp_status_ff, rsp_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              n_last;

   assign n_last = (n_ff == NW'(NODES - 1));

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      cnt_in        = cnt_ff;
      steps_in      = steps_ff;
      rtype_in      = rtype_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      cmd.act       = A_NOP;
      cmd.rsp_load  = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.act = A_CLEAR;
            n_in    = n_ff + 1'b1;
            if (n_last) begin
               n_in     = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.act   = A_LATCH;
               rtype_in  = req_type;
               steps_in  = step_count;
               status_in = ST_OK;
               n_in      = '0;
               case (req_type)
                  REQ_ADD:  state_in = S_ADD_RD;
                  REQ_SET:  state_in = S_SET;
                  REQ_NORM: state_in = N_NODE;
                  REQ_RUN:  state_in = P_START;
                  REQ_READ: state_in = S_READ_RD;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_ADD_RD: begin
            state_in = S_DONE;
            if (sts.node_ok && sts.dest_ok) begin
               cmd.act  = A_RD_REQ;
               state_in = S_ADD_WR;
            end
         end
         S_ADD_WR: begin
            if (sts.full) begin
               status_in = ST_FULL;
            end else begin
               cmd.act = A_ADD_WR;
            end
            state_in = S_DONE;
         end
         S_SET: begin
            if (sts.node_ok) begin
               cmd.act = A_SET_OCC;
            end
            state_in = S_DONE;
         end
         S_READ_RD: begin
            if (sts.node_ok) begin
               cmd.act = A_RD_REQ;
            end
            state_in = S_READ_RES;
         end
         S_READ_RES: begin
            if (sts.node_ok) begin
               cmd.act = A_RES_OCC;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load  = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = (rtype_ff == REQ_RUN && sts.sat) ? ST_SAT : status_ff;
               state_in      = S_IDLE;
            end
         end
         N_NODE: begin
            cmd.act  = A_RD_NODE;
            state_in = N_TOT0;
         end
         N_TOT0: begin
            cmd.act  = A_TOT_CLR;
            cnt_in   = cnt_rd;
            k_in     = '0;
            state_in = N_SUM_RD;
         end
         N_SUM_RD: begin
            if (k_ff == cnt_ff) begin
               state_in = N_CHK;
            end else begin
               cmd.act  = A_RD_LINK;
               state_in = N_SUM_ADD;
            end
         end
         N_SUM_ADD: begin
            cmd.act  = A_TOT_ADD;
            k_in     = k_ff + 1'b1;
            state_in = N_SUM_RD;
         end
         N_CHK: begin
            k_in     = '0;
            state_in = N_DIV_RD;
            if (sts.tot_zero) begin
               n_in     = n_ff + 1'b1;
               state_in = n_last ? S_DONE : N_NODE;
            end
         end
         N_DIV_RD: begin
            if (k_ff == cnt_ff) begin
               n_in     = n_ff + 1'b1;
               state_in = n_last ? S_DONE : N_NODE;
            end else begin
               cmd.act  = A_RD_LINK;
               state_in = N_DIV_GO;
            end
         end
         N_DIV_GO: begin
            cmd.act  = A_DIV_START;
            state_in = N_DIV_WAIT;
         end
         N_DIV_WAIT: begin
            if (sts.div_done) begin
               cmd.act  = A_LINK_WB;
               k_in     = k_ff + 1'b1;
               state_in = N_DIV_RD;
            end
         end
         P_START: begin
            n_in     = '0;
            state_in = (steps_ff == '0) ? S_DONE : P_CLR;
         end
         P_CLR: begin
            cmd.act = A_NEXT_CLR;
            n_in    = n_ff + 1'b1;
            if (n_last) begin
               n_in     = '0;
               state_in = P_NODE;
            end
         end
         P_NODE: begin
            cmd.act  = A_RD_NODE;
            state_in = P_MULP;
         end
         P_MULP: begin
            cmd.act  = A_MUL_P;
            cnt_in   = cnt_rd;
            k_in     = '0;
            state_in = P_LINK;
         end
         P_LINK: begin
            if (k_ff == cnt_ff || sts.p_zero) begin
               n_in     = n_last ? '0 : NW'(n_ff + 1'b1);
               state_in = n_last ? P_CPY_RD : P_NODE;
            end else begin
               cmd.act  = A_RD_LINK;
               state_in = P_MULW;
            end
         end
         P_MULW: begin
            cmd.act  = A_MUL_W;
            state_in = P_COMB;
         end
         P_COMB: begin
            cmd.act  = A_ADD_COMB;
            state_in = P_ACC;
         end
         P_ACC: begin
            cmd.act  = A_ACC_WR;
            k_in     = k_ff + 1'b1;
            state_in = P_LINK;
         end
         P_CPY_RD: begin
            cmd.act  = A_RD_NEXT_N;
            state_in = P_CPY_WR;
         end
         P_CPY_WR: begin
            cmd.act  = A_COPY;
            n_in     = n_ff + 1'b1;
            state_in = P_CPY_RD;
            if (n_last) begin
               n_in     = '0;
               steps_in = steps_ff - 1'b1;
               state_in = P_START;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff          <= k_in;
      cnt_ff        <= cnt_in;
      steps_ff      <= steps_in;
      rtype_ff      <= rtype_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign cmd_node   = n_ff;
   assign cmd_link   = k_ff[LW-1:0];

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !rsp_valid_ff)
      else $error("response raised during clearing pass");

   a_link_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == P_LINK || state_ff == N_SUM_RD || state_ff == N_DIV_RD)
      |-> (k_ff <= cnt_ff))
      else $error("link index ran past link count");

   a_div_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == N_DIV_GO) |=> !sts.div_done)
      else $error("divider done not cleared by start");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == P_LINK) |-> (cnt_ff <= CW'(MAX_LINKS)))
      else $error("link count above list size");
endmodule

>>> rtl/weighted_link_flow_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_link_flow_step_top
// Sparse weighted graph with per-node occupancy and propagation steps.
// ----------------------------------------------------------------------------
// Usage:
//  - req_chan carries one request (add link, set occupancy, normalize,
//    run steps, read occupancy); it is taken when valid and ready are high.
//  - rsp_chan returns one response per request: occupancy for a read,
//    status 1 when a link list is full, status 2 when a step saturated.
//  - csr_wr_en/csr_wr_data write the Q4.12 gain; write only while idle.
// Normalize divides each link weight in turn on one shared divider;
//  run steps performs one link read-multiply-accumulate into the
//  next-occupancy RAM at a time.
// One request is in flight at a time; ready rises again once its response
//  sits in the output register, so the next request overlaps a stalled
//  response. A stalled receiver holds the response and parks the
//  sequencer at its last step until the slot frees.
// Reset: a clearing pass over every node zeroes link counts and occupancies;
//  ready stays low until it finishes. Gain returns to 1.1.
// ----------------------------------------------------------------------------
module weighted_link_flow_step_top #(
   parameter int NODES     = 1024,
   parameter int MAX_LINKS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   wlf_req_if.sink                   req_chan,
   wlf_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [wlf_pkg::GAIN_W-1:0] csr_wr_data
);
   import wlf_pkg::*;

   localparam int NW = $clog2(NODES);
   localparam int LW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
   localparam int CW = $clog2(MAX_LINKS + 1);

   cmd_type       cmd;
   sts_type       sts;
   logic [NW-1:0] cmd_node;
   logic [LW-1:0] cmd_link;
   logic [CW-1:0] cnt_rd;

   // sequencer: owns the handshake and all loop counters
   wlf_ctrl #(.NODES(NODES), .MAX_LINKS(MAX_LINKS)) u_ctrl (
      .clock, .reset,
      .req_valid(req_chan.valid), .req_ready(req_chan.ready),
      .req_type(req_chan.req_type), .step_count(req_chan.step_count),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .rsp_status(rsp_chan.status),
      .cmd, .cmd_node, .cmd_link, .sts, .cnt_rd);

   // datapath: memories, gain, arithmetic; acts on commands, and on CSR writes for the gain
   wlf_datapath #(.NODES(NODES), .MAX_LINKS(MAX_LINKS)) u_dp (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .node(req_chan.node), .dest_node(req_chan.dest_node),
      .raw_weight(req_chan.raw_weight), .occupancy_in(req_chan.occupancy_in),
      .cmd, .cmd_node, .cmd_link, .sts, .cnt_rd,
      .rsp_occ(rsp_chan.occupancy_out));
endmodule
